@@ sv/srp_pkg.sv @@
package srp_pkg;

  localparam int MAX_RECTS   = 64;
  localparam int SIZE_BITS   = 13;
  localparam int IDX_W       = $clog2(MAX_RECTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int CW          = 22;
  localparam int OUT_W       = 20;
  localparam int PROD_W      = 2 * SIZE_BITS;
  localparam int TOT_W       = PROD_W + IDX_W + 1;
  localparam int SQ_W        = (TOT_W + 1) / 2;
  localparam int SQV_W       = 2 * SQ_W;
  localparam int REM_W       = SQ_W + 2;
  localparam int SQC_W       = $clog2(SQ_W);
  localparam int GROW_DIV    = 100;
  localparam int GROW_SHIFT  = 28;
  localparam int GROW_RECIP  = (1 << GROW_SHIFT) / GROW_DIV;
  localparam int GROW_RW     = 22;
  localparam int GPROD_W     = CW + GROW_RW;
  localparam int QUO_W       = CW - 6;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_RANK_INIT,
    OP_RANK_RDI,
    OP_RANK_HI,
    OP_RANK_RDJ,
    OP_RANK_CMP,
    OP_RANK_WR,
    OP_AREA_INIT,
    OP_AREA_RD,
    OP_AREA_MUL,
    OP_AREA_ACC,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_PACK_INIT,
    OP_PACK_RDS,
    OP_PACK_RDI,
    OP_PACK_EVAL,
    OP_GROW_MUL,
    OP_GROW_SET,
    OP_OUT_INIT,
    OP_OUT_RDS,
    OP_OUT_RDP,
    OP_OUT_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RK_INIT,
    ST_RK_RDI,
    ST_RK_HI,
    ST_RK_RDJ,
    ST_RK_CMP,
    ST_RK_WR,
    ST_AR_INIT,
    ST_AR_RD,
    ST_AR_MUL,
    ST_AR_ACC,
    ST_SQ_INIT,
    ST_SQ_STEP,
    ST_PK_INIT,
    ST_PK_RDS,
    ST_PK_RDI,
    ST_PK_EVAL,
    ST_GR_MUL,
    ST_GR_SET,
    ST_OUT_INIT,
    ST_OUT_RDS,
    ST_OUT_RDP,
    ST_OUT_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic i_last;
    logic j_last;
    logic k_last;
    logic sq_last;
    logic fail;
  } dp_stat_t;

endpackage

@@ sv/srp_ctrl.sv @@
module srp_ctrl
  import srp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     final_rect_i,
  input  dp_stat_t stat_i,
  output dp_op_e   op_o,
  output logic     busy
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    op_o    = OP_IDLE;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_o = OP_LOAD;
          if (final_rect_i) state_d = ST_RK_INIT;
        end
      end
      ST_RK_INIT: begin
        op_o    = OP_RANK_INIT;
        state_d = ST_RK_RDI;
      end
      ST_RK_RDI: begin
        op_o    = OP_RANK_RDI;
        state_d = ST_RK_HI;
      end
      ST_RK_HI: begin
        op_o    = OP_RANK_HI;
        state_d = ST_RK_RDJ;
      end
      ST_RK_RDJ: begin
        op_o    = OP_RANK_RDJ;
        state_d = ST_RK_CMP;
      end
      ST_RK_CMP: begin
        op_o    = OP_RANK_CMP;
        state_d = stat_i.j_last ? ST_RK_WR : ST_RK_RDJ;
      end
      ST_RK_WR: begin
        op_o    = OP_RANK_WR;
        state_d = stat_i.i_last ? ST_AR_INIT : ST_RK_RDI;
      end
      ST_AR_INIT: begin
        op_o    = OP_AREA_INIT;
        state_d = ST_AR_RD;
      end
      ST_AR_RD: begin
        op_o    = OP_AREA_RD;
        state_d = ST_AR_MUL;
      end
      ST_AR_MUL: begin
        op_o    = OP_AREA_MUL;
        state_d = ST_AR_ACC;
      end
      ST_AR_ACC: begin
        op_o    = OP_AREA_ACC;
        state_d = stat_i.k_last ? ST_SQ_INIT : ST_AR_RD;
      end
      ST_SQ_INIT: begin
        op_o    = OP_SQ_INIT;
        state_d = ST_SQ_STEP;
      end
      ST_SQ_STEP: begin
        op_o = OP_SQ_STEP;
        if (stat_i.sq_last) state_d = ST_PK_INIT;
      end
      ST_PK_INIT: begin
        op_o    = OP_PACK_INIT;
        state_d = ST_PK_RDS;
      end
      ST_PK_RDS: begin
        op_o    = OP_PACK_RDS;
        state_d = ST_PK_RDI;
      end
      ST_PK_RDI: begin
        op_o    = OP_PACK_RDI;
        state_d = ST_PK_EVAL;
      end
      ST_PK_EVAL: begin
        op_o = OP_PACK_EVAL;
        if (stat_i.fail) begin
          state_d = ST_GR_MUL;
        end else if (stat_i.k_last) begin
          state_d = ST_OUT_INIT;
        end else begin
          state_d = ST_PK_RDS;
        end
      end
      ST_GR_MUL: begin
        op_o    = OP_GROW_MUL;
        state_d = ST_GR_SET;
      end
      ST_GR_SET: begin
        op_o    = OP_GROW_SET;
        state_d = ST_PK_INIT;
      end
      ST_OUT_INIT: begin
        op_o    = OP_OUT_INIT;
        state_d = ST_OUT_RDS;
      end
      ST_OUT_RDS: begin
        op_o    = OP_OUT_RDS;
        state_d = ST_OUT_RDP;
      end
      ST_OUT_RDP: begin
        op_o    = OP_OUT_RDP;
        state_d = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        op_o    = OP_OUT_EMIT;
        state_d = stat_i.k_last ? ST_IDLE : ST_OUT_RDS;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/srp_datapath.sv @@
module srp_datapath
  import srp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_op_e               op_i,
  input  logic [SIZE_BITS-1:0] rect_width_i,
  input  logic [SIZE_BITS-1:0] rect_height_i,
  output dp_stat_t             stat_o,
  output logic                 result_valid_o,
  output logic [IDX_W-1:0]     rect_index_o,
  output logic [OUT_W-1:0]     pos_x_o,
  output logic [OUT_W-1:0]     pos_y_o,
  output logic [OUT_W-1:0]     atlas_width_o,
  output logic [OUT_W-1:0]     atlas_height_o,
  output logic                 overflowed_o,
  output logic                 last_result_o
);

  logic [SIZE_BITS-1:0] wmem [MAX_RECTS];
  logic [SIZE_BITS-1:0] hmem [MAX_RECTS];
  logic [IDX_W-1:0]     smem [MAX_RECTS];
  logic [CW-1:0]        pxmem [MAX_RECTS];
  logic [CW-1:0]        pymem [MAX_RECTS];

  logic [CNT_W-1:0]     cnt_q;
  logic                 ovf_q;
  logic [SIZE_BITS-1:0] w_rd_q, h_rd_q, hi_q;
  logic [IDX_W-1:0]     srt_rd_q, idx_q, i_q, j_q, k_q, rank_q;
  logic [CW-1:0]        px_rd_q, py_rd_q;
  logic [PROD_W-1:0]    prod_q;
  logic [TOT_W-1:0]     total_q;
  logic [SQV_W-1:0]     sv_q;
  logic [SQ_W-1:0]      root_q, root_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [SQC_W-1:0]     sq_cnt_q;
  logic [CW-1:0]        s_q, cx_q, cy_q, ch_q, aw_q, ah_q;
  logic [GPROD_W-1:0]   gprod_q;

  logic [IDX_W-1:0]     wh_ra;
  logic                 load_we;
  logic [REM_W+1:0]     rem2, trial;
  logic [CW-1:0]        w_ext, h_ext, ch_cur, cx_adv, cy_new, ch_new;
  logic                 first, fit_x, fit_y;
  logic [QUO_W-1:0]     quo, quo_c;
  logic [CW-1:0]        rem_g, s_next;

  assign load_we = (op_i == OP_LOAD) && (cnt_q < CNT_W'(MAX_RECTS));

  always_comb begin
    case (op_i)
      OP_RANK_RDI: wh_ra = i_q;
      OP_RANK_RDJ: wh_ra = j_q;
      OP_PACK_RDI: wh_ra = srt_rd_q;
      default:     wh_ra = k_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      wmem[cnt_q[IDX_W-1:0]] <= rect_width_i;
      hmem[cnt_q[IDX_W-1:0]] <= rect_height_i;
    end
    w_rd_q <= wmem[wh_ra];
    h_rd_q <= hmem[wh_ra];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_RANK_WR) smem[rank_q] <= i_q;
    srt_rd_q <= smem[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_PACK_EVAL && (fit_x || fit_y)) begin
      pxmem[idx_q] <= fit_x ? cx_q : CW'(1);
      pymem[idx_q] <= fit_x ? cy_q : cy_q + ch_cur;
    end
    px_rd_q <= pxmem[srt_rd_q];
    py_rd_q <= pymem[srt_rd_q];
  end

  // sqrt: two radicand bits per step
  always_comb begin
    rem2  = {rem_q, sv_q[SQV_W-1 -: 2]};
    trial = (REM_W+2)'({root_q, 2'b01});
    if (rem2 >= trial) begin
      rem_d  = REM_W'(rem2 - trial);
      root_d = {root_q[SQ_W-2:0], 1'b1};
    end else begin
      rem_d  = rem2[REM_W-1:0];
      root_d = {root_q[SQ_W-2:0], 1'b0};
    end
  end

  // shelf placement
  always_comb begin
    first  = (k_q == '0);
    w_ext  = CW'(w_rd_q);
    h_ext  = CW'(h_rd_q);
    ch_cur = first ? h_ext + CW'(2) : ch_q;
    fit_x  = (cx_q + w_ext) <= s_q;
    fit_y  = (cy_q + ch_cur + h_ext) <= s_q;
    cx_adv = cx_q + w_ext + CW'(2);
    cy_new = cy_q + ch_cur + CW'(2);
    ch_new = h_ext + CW'(2);
  end

  // side growth: s + floor(s/100), at least s + 1
  always_comb begin
    quo    = gprod_q[GROW_SHIFT +: QUO_W];
    rem_g  = s_q - CW'(quo) * CW'(GROW_DIV);
    quo_c  = (rem_g >= CW'(GROW_DIV)) ? quo + QUO_W'(1) : quo;
    s_next = (quo_c == '0) ? s_q + CW'(1) : s_q + CW'(quo_c);
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_RANK_INIT: begin
        i_q  <= '0;
        aw_q <= '0;
      end
      OP_RANK_HI: begin
        hi_q   <= h_rd_q;
        j_q    <= '0;
        rank_q <= '0;
      end
      OP_RANK_CMP: begin
        if (h_rd_q > hi_q || (h_rd_q == hi_q && j_q < i_q)) rank_q <= rank_q + 1'b1;
        j_q <= j_q + 1'b1;
      end
      OP_RANK_WR: i_q <= i_q + 1'b1;
      OP_AREA_INIT: begin
        k_q     <= '0;
        total_q <= '0;
      end
      OP_AREA_MUL: prod_q <= w_rd_q * h_rd_q;
      OP_AREA_ACC: begin
        total_q <= total_q + TOT_W'(prod_q);
        k_q     <= k_q + 1'b1;
      end
      OP_SQ_INIT: begin
        sv_q     <= SQV_W'(total_q);
        root_q   <= '0;
        rem_q    <= '0;
        sq_cnt_q <= '0;
      end
      OP_SQ_STEP: begin
        sv_q     <= {sv_q[SQV_W-3:0], 2'b00};
        root_q   <= root_d;
        rem_q    <= rem_d;
        sq_cnt_q <= sq_cnt_q + 1'b1;
        s_q      <= CW'(root_d);
      end
      OP_PACK_INIT: begin
        k_q  <= '0;
        cx_q <= CW'(1);
        cy_q <= CW'(1);
      end
      OP_PACK_RDI: idx_q <= srt_rd_q;
      OP_PACK_EVAL: begin
        if (fit_x) begin
          cx_q <= cx_adv;
          if (cx_adv > aw_q) aw_q <= cx_adv;
          ch_q <= ch_cur;
          if (first) ah_q <= cy_q + ch_cur + CW'(1);
          k_q <= k_q + 1'b1;
        end else if (fit_y) begin
          cx_q <= w_ext + CW'(3);
          cy_q <= cy_new;
          ch_q <= ch_new;
          ah_q <= cy_new + ch_new + CW'(1);
          k_q  <= k_q + 1'b1;
        end
      end
      OP_GROW_MUL: gprod_q <= GPROD_W'(s_q) * GPROD_W'(GROW_RECIP);
      OP_GROW_SET: s_q <= s_next;
      OP_OUT_INIT: k_q <= '0;
      OP_OUT_RDP:  idx_q <= srt_rd_q;
      OP_OUT_EMIT: k_q <= k_q + 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (op_i == OP_LOAD) begin
      if (load_we) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        ovf_q <= 1'b1;
      end
    end else if (op_i == OP_OUT_EMIT && stat_o.k_last) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end
  end

  assign stat_o.i_last  = (CNT_W'(i_q) + CNT_W'(1)) == cnt_q;
  assign stat_o.j_last  = (CNT_W'(j_q) + CNT_W'(1)) == cnt_q;
  assign stat_o.k_last  = (CNT_W'(k_q) + CNT_W'(1)) == cnt_q;
  assign stat_o.sq_last = (sq_cnt_q == SQC_W'(SQ_W - 1));
  assign stat_o.fail    = !fit_x && !fit_y;

  assign result_valid_o = (op_i == OP_OUT_EMIT);
  assign rect_index_o   = idx_q;
  assign pos_x_o        = px_rd_q[OUT_W-1:0];
  assign pos_y_o        = py_rd_q[OUT_W-1:0];
  assign atlas_width_o  = aw_q[OUT_W-1:0];
  assign atlas_height_o = ah_q[OUT_W-1:0];
  assign overflowed_o   = ovf_q;
  assign last_result_o  = stat_o.k_last;

endmodule

@@ sv/shelf_rectangle_packer_top.sv @@
// Shelf rectangle packer.
// Input: pulse start with rect_width_i/rect_height_i/final_rect_i; a transfer
// happens at an edge where start is high and busy is low. While loading, busy
// stays low, so one rectangle can be loaded every cycle. Up to 64 are kept;
// later ones are dropped and reported through overflowed_o.
// The transfer with final_rect_i high starts packing and raises busy. The run
// ranks the heights by comparing each stored height with every loaded one,
// sums the areas, takes the square root (two bits per cycle) as the first
// side, then makes packing attempts that place the rectangles in turn; a
// failed attempt stops at the rectangle that does not fit, grows the side and
// starts a new attempt. The results are then emitted.
// Output: one transfer per rectangle, tallest first, each shown for exactly
// one cycle with result_valid_o high; last_result_o marks the final one.
// The receiver cannot stall; each result passes through the read-slot,
// read-position and emit states. Reset clears the loaded count, the overflow flag and the controller.
module shelf_rectangle_packer_top
  import srp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [SIZE_BITS-1:0] rect_width_i,
  input  logic [SIZE_BITS-1:0] rect_height_i,
  input  logic                 final_rect_i,
  output logic                 result_valid_o,
  output logic [IDX_W-1:0]     rect_index_o,
  output logic [OUT_W-1:0]     pos_x_o,
  output logic [OUT_W-1:0]     pos_y_o,
  output logic [OUT_W-1:0]     atlas_width_o,
  output logic [OUT_W-1:0]     atlas_height_o,
  output logic                 overflowed_o,
  output logic                 last_result_o
);

  dp_op_e   op;
  dp_stat_t stat;

  srp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .final_rect_i (final_rect_i),
    .stat_i       (stat),
    .op_o         (op),
    .busy         (busy)
  );

  srp_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .rect_index_o   (rect_index_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .atlas_width_o  (atlas_width_o),
    .atlas_height_o (atlas_height_o),
    .overflowed_o   (overflowed_o),
    .last_result_o  (last_result_o)
  );

endmodule
